// ===== design/kips_pkg.sv =====
package kips_pkg;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] tag;
    } t_entry;

    function automatic logic [63:0] order_key(input logic [63:0] bits);
        return bits[63] ? ~bits : (bits | {1'b1, 63'd0});
    endfunction

endpackage

// ===== design/kips_cell.sv =====
module kips_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_desc,
    input  logic            i_insert,
    input  logic            i_shift,
    input  kips_pkg::t_entry i_x,
    input  kips_pkg::t_entry i_prev,
    input  logic            i_prev_after,
    input  kips_pkg::t_entry i_next,
    output kips_pkg::t_entry o_ent,
    output logic            o_after
);
    import kips_pkg::*;

    t_entry      r_ent;
    t_entry      n_ent;
    logic [63:0] w_ox;
    logic [63:0] w_os;

    // new item goes strictly before this cell's entry; equal keys stay behind
    always_comb begin
        w_ox = order_key(i_x.key);
        w_os = order_key(r_ent.key);
        if (i_desc) begin
            w_ox = ~w_ox;
            w_os = ~w_os;
        end
        o_after = !r_ent.valid || (w_ox < w_os);
    end

    always_comb begin
        n_ent = r_ent;
        if (i_shift) begin
            n_ent = i_next;
        end else if (i_insert && o_after) begin
            n_ent = i_prev_after ? i_prev : i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_ent = r_ent;
endmodule

// ===== design/kips_chain.sv =====
module kips_chain #(
    parameter int MAX_ITEMS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_desc,
    input  logic            i_insert,
    input  logic            i_shift,
    input  kips_pkg::t_entry i_x,
    output kips_pkg::t_entry o_head,
    output logic            o_head_last
);
    import kips_pkg::*;

    t_entry w_ent   [MAX_ITEMS];
    logic   w_after [MAX_ITEMS];

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_after;
        if (g == 0) begin : g_first
            assign w_prev       = '0;
            assign w_prev_after = 1'b0;
        end else begin : g_mid
            assign w_prev       = w_ent[g-1];
            assign w_prev_after = w_after[g-1];
        end
        if (g == MAX_ITEMS - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_ent[g+1];
        end
        kips_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_desc       (i_desc),
            .i_insert     (i_insert),
            .i_shift      (i_shift),
            .i_x          (i_x),
            .i_prev       (w_prev),
            .i_prev_after (w_prev_after),
            .i_next       (w_next),
            .o_ent        (w_ent[g]),
            .o_after      (w_after[g])
        );
    end

    assign o_head      = w_ent[0];
    assign o_head_last = !w_ent[1].valid;
endmodule

// ===== design/key_index_pair_sorter.sv =====
// Latency: the closing item is accepted, its batch shows at the output on the next cycle.
// Throughput: one item per cycle while a batch fills; the batch then drains one pair
// per cycle from the chain head when not stalled; input is stalled until the last pair.
// Every cell compares against the incoming key in parallel; all cells update at once.
// Reset (synchronous, active low) empties the chain, clears count, drop flag, direction.
module key_index_pair_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [63:0]        i_key_bits,
    input  logic signed [31:0] i_tag,
    input  logic               i_last_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [63:0]        o_sorted_key_bits,
    output logic signed [31:0] o_sorted_tag,
    output logic               o_last_result,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_descending
);
    import kips_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic          r_cfg_desc;
    logic          r_desc;
    logic          r_drain;
    logic          r_drop;
    logic [CW-1:0] r_count;
    logic          w_in_xfer;
    logic          w_out_xfer;
    logic          w_full;
    logic          w_insert;
    t_entry        w_x;
    t_entry        w_head_a;
    t_entry        w_head_d;
    logic          w_last_a;
    logic          w_last_d;
    t_entry        w_head;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = o_out_valid && !i_out_stall;
    assign w_full     = (r_count == CW'(MAX_ITEMS));
    assign w_insert   = w_in_xfer && !w_full;
    assign w_x        = '{valid: 1'b1, key: i_key_bits, tag: i_tag};

    kips_chain #(.MAX_ITEMS(MAX_ITEMS)) u_asc (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_desc (1'b0),
        .i_insert (w_insert), .i_shift (w_out_xfer), .i_x (w_x),
        .o_head (w_head_a), .o_head_last (w_last_a)
    );

    kips_chain #(.MAX_ITEMS(MAX_ITEMS)) u_dsc (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_desc (1'b1),
        .i_insert (w_insert), .i_shift (w_out_xfer), .i_x (w_x),
        .o_head (w_head_d), .o_head_last (w_last_d)
    );

    assign w_head            = r_desc ? w_head_d : w_head_a;
    assign o_sorted_key_bits = w_head.key;
    assign o_sorted_tag      = w_head.tag;
    assign o_last_result     = r_desc ? w_last_d : w_last_a;
    assign o_overflow        = r_drop;
    assign o_out_valid       = r_drain;
    assign o_in_stall        = r_drain;
    assign o_cfg_ready       = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_desc <= 1'b0;
            r_desc     <= 1'b0;
            r_drain    <= 1'b0;
            r_drop     <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg_desc <= i_cfg_descending;
            end
            if (w_in_xfer) begin
                if (w_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
                if (i_last_item) begin
                    r_drain <= 1'b1;
                    r_desc  <= r_cfg_desc;
                end
            end
            if (w_out_xfer && o_last_result) begin
                r_drain <= 1'b0;
                r_drop  <= 1'b0;
                r_count <= '0;
            end
        end
    end
endmodule

// ===== design/kips_checker.sv =====
module kips_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_item,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_sorted_key_bits,
    input logic        o_last_result
);
    a_close_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_item) |=> o_out_valid)
        else $error("closing transfer did not start output");

    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during output");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_result) |=> !o_out_valid)
        else $error("output continued past last pair");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sorted_key_bits)))
        else $error("stalled output changed");
endmodule

bind key_index_pair_sorter kips_checker u_kips_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_last_item       (i_last_item),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_sorted_key_bits (o_sorted_key_bits),
    .o_last_result     (o_last_result)
);

// ===== dv/key_index_pair_sorter_tb.sv =====
module key_index_pair_sorter_tb;

    localparam int CAPACITY = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [63:0]        key;
        logic signed [31:0] tag;
        logic               last;
        logic               ovf;
    } t_pair;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [63:0]        i_key_bits;
    logic signed [31:0] i_tag;
    logic               i_last_item;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [63:0]        o_sorted_key_bits;
    logic signed [31:0] o_sorted_tag;
    logic               o_last_result;
    logic               o_overflow;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_descending;

    key_index_pair_sorter #(.MAX_ITEMS(CAPACITY)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_key_bits        (i_key_bits),
        .i_tag             (i_tag),
        .i_last_item       (i_last_item),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sorted_key_bits (o_sorted_key_bits),
        .o_sorted_tag      (o_sorted_tag),
        .o_last_result     (o_last_result),
        .o_overflow        (o_overflow),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_descending  (i_cfg_descending)
    );

    // predictor state
    logic [63:0]        batch_keys[$];
    logic signed [31:0] batch_tags[$];
    logic               batch_dropped;
    logic               sort_desc;
    t_pair              sorted_pending[$];

    int  errors;
    int  items_sent;
    int  pairs_seen;
    int  batches_closed;
    int  cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [63:0] total_order(logic [63:0] bits);
        return bits[63] ? ~bits : {1'b1, bits[62:0]};
    endfunction

    // stable insertion sort of the closed batch, queued as expected pairs
    function automatic void close_batch();
        logic [63:0]        keys[$];
        logic signed [31:0] tags[$];
        int                 j;
        t_pair              p;
        for (int i = 0; i < batch_keys.size(); i++) begin
            j = keys.size();
            while (j > 0 && (sort_desc ?
                   total_order(batch_keys[i]) > total_order(keys[j-1]) :
                   total_order(batch_keys[i]) < total_order(keys[j-1])))
                j--;
            keys.insert(j, batch_keys[i]);
            tags.insert(j, batch_tags[i]);
        end
        for (int i = 0; i < keys.size(); i++) begin
            p.key  = keys[i];
            p.tag  = tags[i];
            p.last = (i == keys.size() - 1);
            p.ovf  = batch_dropped;
            sorted_pending.push_back(p);
        end
        batch_keys.delete();
        batch_tags.delete();
        batch_dropped = 0;
        batches_closed++;
    endfunction

    // valid stays up after a transfer; the next call drives its own item, or an idle step drops it
    task automatic send_item(logic [63:0] key, logic signed [31:0] tag, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_key_bits  <= key;
        i_tag       <= tag;
        i_last_item <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (batch_keys.size() < CAPACITY) begin
            batch_keys.push_back(key);
            batch_tags.push_back(tag);
        end else begin
            batch_dropped = 1;
        end
        if (last) close_batch();
    endtask

    task automatic write_direction(logic desc);
        i_in_valid <= 0;
        while (sorted_pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid      <= 1;
        i_cfg_descending <= desc;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        sort_desc = desc;
    endtask

    // receiver: random stall, or a long counted hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pair exp_pair;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pairs_seen++;
            if (sorted_pending.size() == 0) begin
                errors++;
                $error("unexpected pair key=%h tag=%0d", o_sorted_key_bits, o_sorted_tag);
            end else begin
                exp_pair = sorted_pending.pop_front();
                if (o_sorted_key_bits !== exp_pair.key) begin
                    errors++;
                    $error("sorted_key_bits: expected %h, got %h",
                           exp_pair.key, o_sorted_key_bits);
                end
                if (o_sorted_tag !== exp_pair.tag) begin
                    errors++;
                    $error("sorted_tag: expected %0d, got %0d", exp_pair.tag, o_sorted_tag);
                end
                if (o_last_result !== exp_pair.last) begin
                    errors++;
                    $error("last_result: expected %0b, got %0b",
                           exp_pair.last, o_last_result);
                end
                if (o_overflow !== exp_pair.ovf) begin
                    errors++;
                    $error("overflow: expected %0b, got %0b", exp_pair.ovf, o_overflow);
                end
            end
        end
    end

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(5))
            0: k = {k[63], 11'h3ff, k[51:0] & 52'hf};
            1: k = k[63] ? 64'h8000_0000_0000_0000 : 64'h0;
            2: k = {k[63], 11'h7ff, 52'h0};
            default: if (k[62:52] == 11'h7ff) k[62] = 0;
        endcase
        return k;
    endfunction

    task automatic test_directed();
        send_item(64'h0, 1, 0);
        send_item(64'h8000_0000_0000_0000, 2, 0);
        send_item(64'h7ff0_0000_0000_0000, 3, 0);
        send_item(64'hfff0_0000_0000_0000, 4, 0);
        send_item(64'h3ff0_0000_0000_0000, 32'sh7fffffff, 0);
        send_item(64'hbff0_0000_0000_0000, 32'sh80000000, 0);
        send_item(64'h3ff0_0000_0000_0000, -1, 0);
        send_item(64'h0000_0000_0000_0001, 0, 0);
        send_item(64'h7fef_ffff_ffff_ffff, 5, 1);
        send_item(64'h7fff_ffff_ffff_ffff, 6, 0);
        send_item(64'hffff_ffff_ffff_ffff, 7, 0);
        send_item(64'h4000_0000_0000_0000, 8, 1);
        send_item(64'h1234_5678_9abc_def0, 9, 1);
    endtask

    task automatic test_descending();
        write_direction(1);
        for (int i = 0; i < 8; i++)
            send_item(rand_key(), $urandom, i == 7);
        write_direction(0);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < CAPACITY + 3; i++)
            send_item(rand_key(), $urandom, i == CAPACITY + 2);
        for (int i = 0; i < CAPACITY; i++)
            send_item(rand_key(), $urandom, i == CAPACITY - 1);
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 20; i++)
            send_item(rand_key(), $urandom, i == 9 || i == 19);
    endtask

    task automatic test_random(int n);
        int len;
        len = 0;
        for (int i = 0; i < n; i++) begin
            len++;
            send_item(rand_key(), $urandom,
                      i == n - 1 || $urandom_range(len * 2 + 1) > 4);
            if (i_last_item) len = 0;
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_key_bits = 0;
        i_tag = 0;
        i_last_item = 0;
        i_cfg_valid = 0;
        i_cfg_descending = 0;
        errors = 0;
        items_sent = 0;
        pairs_seen = 0;
        batches_closed = 0;
        batch_dropped = 0;
        sort_desc = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        test_directed();
        test_descending();
        test_overflow();
        test_backpressure();
        test_random(20);
        send_idle_pct = 67;
        test_random(20);
        write_direction(1);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        test_random(20);
        send_idle_pct = 10;
        recv_stall_pct = 10;
        test_random(20);
        write_direction(0);
        test_random(20);

        i_in_valid <= 0;
        while (sorted_pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d items in %0d batches, checked %0d sorted pairs,",
                 items_sent, batches_closed, pairs_seen);
        $display("both directions, overflow, extremes, idle/stall mixes and a long hold-off.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
